FILE: rtl/circ_pkg.sv
// circ_pkg: shared types and constants for the circle rasterizer
// opcodes, fixed field widths and the queue status bundle; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package circ_pkg;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // point coordinates and decision variable have fixed widths
  localparam int POINT_W = 14;
  localparam int DEC_W   = 16;

  // runs that can wait between the step logic and the point emitter
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/circle_rasterizer_top.sv
// circle_rasterizer_top: midpoint circle rasterizer, front step logic,
// run queue and point emitter; depends on circ_pkg, circ_front, circ_queue, circ_back
//
//   channel  ports                                       direction  beat
//   in       in_valid/in_stall, opcode, center, radius   input      one command
//   out      out_valid/out_stall, point, last, done      output     one point
//
// a start or an active advance yields eight points, one per cycle unless out_stall holds them;
// the emitter holds a single point at a time in its output register
// an advance with no circle in progress is accepted and yields no point
// the first point passes the run queue, the emitter run registers and its output register; two runs can wait queued
// reset (rst_n low at a clock edge) clears the step state, the queue and out_valid
// out_stall holds the current point; in_stall rises only when the run queue is full
`timescale 1ns / 1ps
`default_nettype none

module circle_rasterizer_top #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_opcode,
  input  wire logic [COORD_BITS-1:0]               in_center_x,
  input  wire logic [COORD_BITS-1:0]               in_center_y,
  input  wire logic [RADIUS_BITS-1:0]              in_radius,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [circ_pkg::POINT_W-1:0]      out_point_x,
  output logic signed [circ_pkg::POINT_W-1:0]      out_point_y,
  output logic                                     out_last_of_run,
  output logic                                     out_circle_done
);

  localparam int RUN_W = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + 1;

  circ_pkg::q_status_t q_status;
  logic                push;
  logic                pop;
  logic [RUN_W-1:0]    push_data;
  logic [RUN_W-1:0]    pop_data;

  circ_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .RUN_W       (RUN_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  circ_queue #(
    .WIDTH (RUN_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  circ_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .RUN_W       (RUN_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .pop_data        (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_last_of_run (out_last_of_run),
    .out_circle_done (out_circle_done)
  );

endmodule

`default_nettype wire

FILE: rtl/circ_queue.sv
// circ_queue: small register queue of pending runs between front and back
// uses circ_pkg for depth and the status bundle
`timescale 1ns / 1ps
`default_nettype none

module circ_queue #(
  parameter int WIDTH = 63
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic [WIDTH-1:0]    push_data,
  input  wire logic                pop,
  output logic      [WIDTH-1:0]    pop_data,
  output circ_pkg::q_status_t      status
);

  localparam int DEPTH = circ_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = mem_r[rd_ptr_r];
  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !status.empty)
    else $error("queue empty after a lone push");

endmodule

`default_nettype wire

FILE: rtl/circ_front.sv
// circ_front: accepts start and advance beats and runs the decision step
// pushes one run (center, x, y, done) per emitting beat; uses circ_pkg
`timescale 1ns / 1ps
`default_nettype none

module circ_front #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11,
  parameter int RUN_W       = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_opcode,
  input  wire logic [COORD_BITS-1:0]    in_center_x,
  input  wire logic [COORD_BITS-1:0]    in_center_y,
  input  wire logic [RADIUS_BITS-1:0]   in_radius,
  input  wire circ_pkg::q_status_t      q_status,
  output logic                          push,
  output logic      [RUN_W-1:0]         push_data
);

  // x and y stay within -1 .. 2**RADIUS_BITS
  localparam int XW    = RADIUS_BITS + 2;
  localparam int DEC_W = circ_pkg::DEC_W;

  logic [COORD_BITS-1:0]  cx_r, cx_nxt;
  logic [COORD_BITS-1:0]  cy_r, cy_nxt;
  logic signed [XW-1:0]   x_r, x_nxt;
  logic signed [XW-1:0]   y_r, y_nxt;
  logic [DEC_W-1:0]       dec_r, dec_nxt;
  logic                   active_r, active_nxt;

  logic                   accept;
  logic                   done;
  logic signed [31:0]     dec_ext, x_ext, y_ext, r_ext;
  logic signed [31:0]     sum_neg, sum_pos, dec_init;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  assign dec_ext  = {{(32 - DEC_W){dec_r[DEC_W-1]}}, dec_r};
  assign x_ext    = {{(32 - XW){x_r[XW-1]}}, x_r};
  assign y_ext    = {{(32 - XW){y_r[XW-1]}}, y_r};
  assign r_ext    = {{(32 - RADIUS_BITS){1'b0}}, in_radius};
  assign sum_neg  = dec_ext + (x_ext <<< 2) + 32'sd6;
  assign sum_pos  = dec_ext + ((x_ext - y_ext) <<< 2) + 32'sd10;
  assign dec_init = 32'sd3 - (r_ext <<< 1);

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dec_nxt    = dec_r;
    active_nxt = active_r;
    done       = 1'b0;
    push       = 1'b0;
    if (accept) begin
      if (in_opcode == circ_pkg::OP_START) begin
        cx_nxt     = in_center_x;
        cy_nxt     = in_center_y;
        x_nxt      = '0;
        y_nxt      = XW'(r_ext);
        dec_nxt    = dec_init[DEC_W-1:0];
        active_nxt = 1'b1;
        push       = 1'b1;
      end else if (active_r) begin
        if (dec_r[DEC_W-1]) begin
          dec_nxt = sum_neg[DEC_W-1:0];
        end else begin
          dec_nxt = sum_pos[DEC_W-1:0];
          y_nxt   = y_r - XW'(1);
        end
        x_nxt = x_r + XW'(1);
        done  = (x_nxt > y_nxt);
        if (done) begin
          active_nxt = 1'b0;
        end
        push = 1'b1;
      end
    end
  end

  assign push_data = {cx_nxt, cy_nxt, x_nxt, y_nxt, done};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      x_r      <= '0;
      y_r      <= '0;
      dec_r    <= '0;
      active_r <= 1'b0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      dec_r    <= dec_nxt;
      active_r <= active_nxt;
    end
  end

  a_idle_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == circ_pkg::OP_ADVANCE && !active_r) |-> !push)
    else $error("advance with no circle produced a run");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (push && done) |=> !active_r)
    else $error("circle still active after its final run");

  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == circ_pkg::OP_START) |=> active_r)
    else $error("start did not open a circle");

endmodule

`default_nettype wire

FILE: rtl/circ_back.sv
// circ_back: takes queued runs and emits their eight mirrored points
// one point per cycle unless stalled, via an output register; uses circ_pkg
`timescale 1ns / 1ps
`default_nettype none

module circ_back #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11,
  parameter int RUN_W       = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + 1
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire circ_pkg::q_status_t                    q_status,
  input  wire logic [RUN_W-1:0]                       pop_data,
  output logic                                        pop,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [circ_pkg::POINT_W-1:0]         out_point_x,
  output logic signed [circ_pkg::POINT_W-1:0]         out_point_y,
  output logic                                        out_last_of_run,
  output logic                                        out_circle_done
);

  localparam int XW = RADIUS_BITS + 2;
  localparam int PW = circ_pkg::POINT_W;

  logic [COORD_BITS-1:0]  cx_r;
  logic [COORD_BITS-1:0]  cy_r;
  logic signed [XW-1:0]   x_r;
  logic signed [XW-1:0]   y_r;
  logic                   done_r;
  logic                   busy_r, busy_nxt;
  logic [2:0]             idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [PW-1:0]   px_r, py_r;
  logic                   last_r, cdone_r;

  logic                   advance;
  logic signed [XW-1:0]   off_x, off_y;
  logic signed [31:0]     ox_ext, oy_ext, px_sum, py_sum;

  // a point leaves the run when the output register is free or draining
  assign advance = busy_r && (!out_valid_r || !out_stall);
  assign pop     = !q_status.empty && (!busy_r || (advance && idx_r == 3'd7));

  // octant order: index bit 2 swaps x and y, bit 0 negates x, bit 1 negates y
  assign off_x  = idx_r[2] ? y_r : x_r;
  assign off_y  = idx_r[2] ? x_r : y_r;
  assign ox_ext = {{(32 - XW){off_x[XW-1]}}, off_x};
  assign oy_ext = {{(32 - XW){off_y[XW-1]}}, off_y};
  assign px_sum = {{(32 - COORD_BITS){1'b0}}, cx_r} + (idx_r[0] ? -ox_ext : ox_ext);
  assign py_sum = {{(32 - COORD_BITS){1'b0}}, cy_r} + (idx_r[1] ? -oy_ext : oy_ext);

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 3'd1;
      if (idx_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      {cx_r, cy_r, x_r, y_r, done_r} <= pop_data;
    end
    if (advance) begin
      px_r    <= px_sum[PW-1:0];
      py_r    <= py_sum[PW-1:0];
      last_r  <= (idx_r == 3'd7);
      cdone_r <= done_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = px_r;
  assign out_point_y     = py_r;
  assign out_last_of_run = last_r;
  assign out_circle_done = cdone_r;

  a_pop_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && busy_r) |-> (advance && idx_r == 3'd7))
    else $error("new run loaded in the middle of a run");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && idx_r == 3'd7 && !pop) |=> !busy_r)
    else $error("emitter busy after the eighth point");

  a_first_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (busy_r && idx_r == 3'd0))
    else $error("run not started at the first point");

endmodule

`default_nettype wire

FILE: tb/sv/tb_circle_rasterizer_top.sv
// tb_circle_rasterizer_top: self-checking bench for the midpoint circle rasterizer
// predicts every mirrored point of each step and checks the point stream in order
// depends on circ_pkg and circle_rasterizer_top
`timescale 1ns / 1ps

module tb_circle_rasterizer_top;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    logic signed [circ_pkg::POINT_W-1:0] px;
    logic signed [circ_pkg::POINT_W-1:0] py;
    logic                                last;
    logic                                done;
  } pixel_t;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_stall;
  logic                                  in_opcode;
  logic [COORD_BITS-1:0]                 in_center_x;
  logic [COORD_BITS-1:0]                 in_center_y;
  logic [RADIUS_BITS-1:0]                in_radius;
  logic                                  out_valid;
  logic                                  out_stall;
  logic signed [circ_pkg::POINT_W-1:0]   out_point_x;
  logic signed [circ_pkg::POINT_W-1:0]   out_point_y;
  logic                                  out_last_of_run;
  logic                                  out_circle_done;

  // predictor state
  logic [COORD_BITS-1:0]                 ctr_x;
  logic [COORD_BITS-1:0]                 ctr_y;
  logic signed [COORD_BITS:0]            walk_x;
  logic signed [COORD_BITS:0]            walk_y;
  logic signed [circ_pkg::DEC_W-1:0]     decision;
  logic                                  circle_on;

  pixel_t pending_pts[$];

  int errors          = 0;
  int items_sent      = 0;
  int circles_started = 0;
  int circles_done    = 0;
  int points_checked  = 0;
  int in_held_cycles  = 0;
  int hold_req        = 0;
  bit in_quiet        = 1'b0;
  bit out_quiet       = 1'b0;

  circle_rasterizer_top #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_of_run(out_last_of_run),
    .out_circle_done(out_circle_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // eight mirrored points of the current step, in emitter order
  function automatic void queue_run(input logic done);
    logic signed [circ_pkg::POINT_W-1:0] cx, cy, x, y;
    logic signed [circ_pkg::POINT_W-1:0] xs[8];
    logic signed [circ_pkg::POINT_W-1:0] ys[8];
    pixel_t pt;
    cx = $signed({2'b00, ctr_x});
    cy = $signed({2'b00, ctr_y});
    x  = circ_pkg::POINT_W'(walk_x);
    y  = circ_pkg::POINT_W'(walk_y);
    xs = '{cx + x, cx - x, cx + x, cx - x, cx + y, cx - y, cx + y, cx - y};
    ys = '{cy + y, cy + y, cy - y, cy - y, cy + x, cy + x, cy - x, cy - x};
    for (int k = 0; k < 8; k++) begin
      pt.px   = xs[k];
      pt.py   = ys[k];
      pt.last = (k == 7);
      pt.done = done;
      pending_pts.push_back(pt);
    end
  endfunction

  function automatic void predict_cmd(input logic op, input logic [COORD_BITS-1:0] cx,
                                      input logic [COORD_BITS-1:0] cy,
                                      input logic [RADIUS_BITS-1:0] r);
    int d;
    if (op == circ_pkg::OP_START) begin
      ctr_x     = cx;
      ctr_y     = cy;
      walk_x    = '0;
      walk_y    = (COORD_BITS+1)'(r);
      decision  = circ_pkg::DEC_W'(3 - 2 * int'(r));
      circle_on = 1'b1;
      circles_started++;
      items_sent++;
      queue_run(1'b0);
    end else if (circle_on) begin
      items_sent++;
      d = int'(decision);
      if (d < 0) begin
        d += 4 * int'(walk_x) + 6;
      end else begin
        d += 4 * (int'(walk_x) - int'(walk_y)) + 10;
        walk_y = walk_y - (COORD_BITS+1)'(1);
      end
      walk_x   = walk_x + (COORD_BITS+1)'(1);
      decision = circ_pkg::DEC_W'(d);
      // the overshoot step closes the circle
      if (walk_x > walk_y) begin
        circle_on = 1'b0;
        circles_done++;
        queue_run(1'b1);
      end else begin
        queue_run(1'b0);
      end
    end
  endfunction

  function automatic int pick_gap();
    int p;
    if (in_quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // call only at a rising edge; valid stays up when the next beat follows at once
  task automatic send_cmd(input logic op, input logic [COORD_BITS-1:0] cx,
                          input logic [COORD_BITS-1:0] cy,
                          input logic [RADIUS_BITS-1:0] r);
    int gap;
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius   <= r;
    do @(posedge clk); while (in_stall);
    predict_cmd(op, cx, cy, r);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // center and radius are don't-care on an advance, so scramble them
  task automatic send_advance();
    send_cmd(circ_pkg::OP_ADVANCE, COORD_BITS'($urandom_range(0, 4095)),
             COORD_BITS'($urandom_range(0, 4095)), RADIUS_BITS'($urandom_range(0, 2047)));
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pts.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_advance();
    send_cmd(circ_pkg::OP_ADVANCE, '1, '1, '1);
    send_cmd(circ_pkg::OP_ADVANCE, '0, '0, '0);
    drain_points();
  endtask

  task automatic test_zero_radius();
    send_cmd(circ_pkg::OP_START, 12'd0, 12'd4095, 11'd0);
    send_advance();
    send_advance();
    drain_points();
  endtask

  task automatic test_extreme_fields();
    send_cmd(circ_pkg::OP_START, 12'd4095, 12'd4095, 11'd2047);
    send_advance();
    send_advance();
    // restart while a circle is in progress
    send_cmd(circ_pkg::OP_START, 12'd0, 12'd0, 11'd2047);
    send_advance();
    send_cmd(circ_pkg::OP_START, 12'd4095, 12'd0, 11'd1);
    while (circle_on) send_advance();
    drain_points();
  endtask

  task automatic test_full_circle();
    send_cmd(circ_pkg::OP_START, 12'd1000, 12'd2000, 11'd5);
    while (circle_on) send_advance();
    send_advance();
    drain_points();
  endtask

  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    in_quiet = 1'b1;
    send_cmd(circ_pkg::OP_START, COORD_BITS'($urandom_range(0, 4095)),
             COORD_BITS'($urandom_range(0, 4095)), 11'd60);
    for (int k = 0; k < 12; k++) send_advance();
    in_quiet = 1'b0;
    drain_points();
  endtask

  task automatic test_random_circles();
    int target, kind, r, max_steps, n;
    target = items_sent + 180;
    while (items_sent < target) begin
      if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
      if ($urandom_range(0, 15) == 0) out_quiet = !out_quiet;
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        send_advance();
      end else begin
        if (kind < 16) r = $urandom_range(0, 2047);
        else r = $urandom_range(0, 20);
        send_cmd(circ_pkg::OP_START, COORD_BITS'($urandom_range(0, 4095)),
                 COORD_BITS'($urandom_range(0, 4095)), RADIUS_BITS'(r));
        if (kind < 16) max_steps = $urandom_range(0, 3);
        else if (kind < 30) max_steps = $urandom_range(0, 6);
        else max_steps = 1 << 20;
        n = 0;
        while (circle_on && n < max_steps) begin
          send_advance();
          n++;
        end
      end
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    drain_points();
  endtask

  // point checker and output stall generator
  initial begin
    pixel_t want;
    int stall_left, hold_left, p;
    logic stall_next;
    out_stall <= 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_pts.size() == 0) begin
          $error("point (%0d,%0d) arrived with no point expected", out_point_x, out_point_y);
          errors++;
        end else begin
          want = pending_pts.pop_front();
          points_checked++;
          if (out_point_x !== want.px) begin
            $error("point_x: expected %0d, got %0d", want.px, out_point_x);
            errors++;
          end
          if (out_point_y !== want.py) begin
            $error("point_y: expected %0d, got %0d", want.py, out_point_y);
            errors++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
            errors++;
          end
          if (out_circle_done !== want.done) begin
            $error("circle_done: expected %0d, got %0d", want.done, out_circle_done);
            errors++;
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      stall_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (!out_quiet) begin
        p = $urandom_range(0, 99);
        if (p >= 75) begin
          stall_left = (p >= 96) ? $urandom_range(10, 40) : $urandom_range(1, 3);
          stall_left--;
          stall_next = 1'b1;
        end
      end
      out_stall <= stall_next;
    end
  end

  // watchdog on cycles where neither channel moves a beat
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && in_valid && in_stall) in_held_cycles++;
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= circ_pkg::OP_START;
    in_center_x <= '0;
    in_center_y <= '0;
    in_radius   <= '0;
    ctr_x     = '0;
    ctr_y     = '0;
    walk_x    = '0;
    walk_y    = '0;
    decision  = '0;
    circle_on = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_advance();
    test_zero_radius();
    test_extreme_fields();
    test_full_circle();
    test_backpressure();
    test_random_circles();

    drain_points();
    repeat (20) @(posedge clk);
    $display("tb: %0d commands, %0d circles started, %0d closed, %0d points checked",
             items_sent, circles_started, circles_done, points_checked);
    $display("tb: input held off %0d cycles by a full run queue, %0d mismatches",
             in_held_cycles, errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
